// File: rtl/core/ttns_pkg.sv
// ----------------------------------------------------------------------------
// ttns_pkg - shared types and constants of the note sequencer
// Word layouts, request and register codes, sequencer states and the address
// fold used to bring a byte address into the note memory range.
// ----------------------------------------------------------------------------
package ttns_pkg;

  localparam int unsigned NOTE_DEPTH_DEF = 256;
  localparam int unsigned US_PER_MS      = 1000;
  localparam int unsigned TIME_W         = 48;
  localparam int unsigned SONG_W         = 9;
  localparam int unsigned FREQ_W         = 16;
  localparam int unsigned MS_W           = 16;
  // Largest note length in microseconds is 65535 * 1000, which fits 26 bits
  localparam int unsigned NEED_W         = $clog2(65535 * US_PER_MS + 1);

  // Request codes
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_PLAY_FX = 3'd1;
  localparam logic [2:0] REQ_PLAY_BG = 3'd2;
  localparam logic [2:0] REQ_STOP    = 3'd3;
  localparam logic [2:0] REQ_CHECK   = 3'd4;

  // Configuration register indexes
  localparam logic CFG_MUSIC_MUTED   = 1'b0;
  localparam logic CFG_EFFECTS_MUTED = 1'b1;

  // Track slots
  localparam logic TRK_FX = 1'b0;
  localparam logic TRK_BG = 1'b1;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [7:0]        entry_addr;
    logic [FREQ_W-1:0] entry_freq;
    logic [MS_W-1:0]   entry_ms;
    logic [7:0]        song_start;
    logic [SONG_W-1:0] song_notes;
    logic              song_repeats;
    logic [TIME_W-1:0] now_us;
  } in_word_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq;
    logic              effect_busy;
    logic              music_busy;
  } out_word_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [MS_W-1:0]   len_ms;
  } note_t;

  localparam int unsigned NOTE_W = $bits(note_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLAY_RD,
    ST_CHK_START,
    ST_CHK_LEN,
    ST_CHK_CMP,
    ST_CHK_FRQ,
    ST_DONE
  } seq_state_t;

  // Remainder of a byte address by the memory depth: restoring steps with
  // shifted copies of the depth, each a narrow compare and subtract.
  function automatic logic [8:0] wrap_addr(input logic [7:0] v, input int unsigned depth);
    logic [9:0]      r;
    longint unsigned step;
    r = {2'b00, v};
    for (int k = 8; k >= 0; k--) begin
      step = longint'(depth) << k;
      if (step <= 64'd511) begin
        if (r >= 10'(step)) begin
          r = r - 10'(step);
        end
      end
    end
    return r[8:0];
  endfunction

endpackage

// File: rtl/core/ttns_ram.sv
// ----------------------------------------------------------------------------
// ttns_ram - single port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module ttns_ram #(
  parameter int unsigned WIDTH = ttns_pkg::NOTE_W,
  parameter int unsigned DEPTH = ttns_pkg::NOTE_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/ttns_elapsed.sv
// ----------------------------------------------------------------------------
// ttns_elapsed - note length check
// Register the note length in microseconds and the time since note start,
// then compare in the following cycle.
// ----------------------------------------------------------------------------
module ttns_elapsed (
  input  logic                         clk,
  input  logic [ttns_pkg::TIME_W-1:0]  now_us,
  input  logic [ttns_pkg::TIME_W-1:0]  since_us,
  input  logic [ttns_pkg::MS_W-1:0]    len_ms,
  output logic                         elapsed
);
  import ttns_pkg::*;

  logic [NEED_W-1:0] need_r, need_nxt;
  logic [TIME_W-1:0] diff_r, diff_nxt;
  logic              ge_r, ge_nxt;
  logic [TIME_W:0]   sub;

  always_comb begin
    need_nxt = NEED_W'(len_ms) * NEED_W'(US_PER_MS);
    sub      = {1'b0, now_us} - {1'b0, since_us};
    diff_nxt = sub[TIME_W-1:0];
    // clock running back means the note has not elapsed
    ge_nxt   = !sub[TIME_W];
  end

  always_ff @(posedge clk) begin
    need_r <= need_nxt;
    diff_r <= diff_nxt;
    ge_r   <= ge_nxt;
  end

  assign elapsed = ge_r && (diff_r >= TIME_W'(need_r));

endmodule

// File: rtl/core/ttns_seq.sv
// ----------------------------------------------------------------------------
// ttns_seq - request sequencer and track state
// Take one request at a time, walk the note memory reads it needs, update
// the two tracks and the tone, and hold the result word for the receiver.
// ----------------------------------------------------------------------------
module ttns_seq #(
  parameter int unsigned NOTE_DEPTH = ttns_pkg::NOTE_DEPTH_DEF,
  localparam int unsigned AW        = $clog2(NOTE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ttns_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ttns_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic                        cfg_wdata,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_addr,
  output ttns_pkg::note_t             mem_wdata,
  input  ttns_pkg::note_t             mem_rdata,
  output logic [ttns_pkg::TIME_W-1:0] chk_now,
  output logic [ttns_pkg::TIME_W-1:0] chk_since,
  input  logic                        chk_elapsed
);
  import ttns_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic              music_muted_r, music_muted_nxt;
  logic              effects_muted_r, effects_muted_nxt;
  logic [FREQ_W-1:0] sounding_r, sounding_nxt;
  logic              trk_r, trk_nxt;
  logic              act_r, act_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  // track slots, indexed by TRK_FX / TRK_BG
  logic [1:0]        on_r, on_nxt;
  logic [1:0]        loop_r, loop_nxt;
  logic [AW-1:0]     base_r [2];
  logic [AW-1:0]     base_nxt [2];
  logic [AW-1:0]     addr_r [2];
  logic [AW-1:0]     addr_nxt [2];
  logic [SONG_W-1:0] count_r [2];
  logic [SONG_W-1:0] count_nxt [2];
  logic [SONG_W-1:0] pos_r [2];
  logic [SONG_W-1:0] pos_nxt [2];
  logic [TIME_W-1:0] since_r [2];
  logic [TIME_W-1:0] since_nxt [2];

  logic              accept;
  logic [AW+8:0]     wr_ext, st_ext;
  logic [AW-1:0]     wr_addr, start_addr;
  logic [AW:0]       addr_inc;
  logic [AW-1:0]     step_addr, new_addr;
  logic [SONG_W-1:0] pos_inc, new_pos;
  logic              wrap_song, goes_on;
  logic              leave, live;
  logic              start_trk;
  logic              start_snd;

  assign accept = in_valid && !in_stall;

  // fold byte addresses into the memory range
  assign wr_ext     = {AW'(0), wrap_addr(in_data.entry_addr, NOTE_DEPTH)};
  assign st_ext     = {AW'(0), wrap_addr(in_data.song_start, NOTE_DEPTH)};
  assign wr_addr    = wr_ext[AW-1:0];
  assign start_addr = st_ext[AW-1:0];

  // advance of the current track by one note
  assign addr_inc  = {1'b0, addr_r[trk_r]} + (AW+1)'(1);
  assign step_addr = (addr_inc == (AW+1)'(NOTE_DEPTH)) ? '0 : addr_inc[AW-1:0];
  assign pos_inc   = pos_r[trk_r] + SONG_W'(1);
  assign wrap_song = loop_r[trk_r] && (pos_inc == count_r[trk_r]);
  assign new_pos   = wrap_song ? '0 : pos_inc;
  assign new_addr  = wrap_song ? base_r[trk_r] : step_addr;
  assign goes_on   = wrap_song || (pos_inc < count_r[trk_r]);

  assign chk_now   = now_r;
  assign chk_since = since_r[trk_r];

  always_comb begin
    state_nxt         = state_r;
    music_muted_nxt   = music_muted_r;
    effects_muted_nxt = effects_muted_r;
    sounding_nxt      = sounding_r;
    trk_nxt           = trk_r;
    act_nxt           = act_r;
    now_nxt           = now_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_data_nxt      = out_data_r;
    on_nxt            = on_r;
    loop_nxt          = loop_r;
    base_nxt          = base_r;
    addr_nxt          = addr_r;
    count_nxt         = count_r;
    pos_nxt           = pos_r;
    since_nxt         = since_r;
    mem_we            = 1'b0;
    mem_addr          = addr_r[trk_r];
    mem_wdata         = '{freq: in_data.entry_freq, len_ms: in_data.entry_ms};
    in_stall          = (state_r != ST_IDLE);
    leave             = 1'b0;
    live              = 1'b0;
    start_trk         = TRK_FX;
    start_snd         = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MUSIC_MUTED:   music_muted_nxt   = cfg_wdata;
        CFG_EFFECTS_MUTED: effects_muted_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt   = in_data.now_us;
          state_nxt = ST_DONE;
          case (in_data.req_type)
            REQ_WRITE: begin
              mem_we   = 1'b1;
              mem_addr = wr_addr;
            end
            REQ_PLAY_FX: begin
              if (!effects_muted_r) begin
                start_trk = TRK_FX;
                start_snd = 1'b1;
              end
            end
            REQ_PLAY_BG: begin
              if (!music_muted_r) begin
                start_trk = TRK_BG;
                start_snd = !on_r[TRK_FX];
              end
            end
            REQ_STOP: begin
              if (!(music_muted_r && effects_muted_r)) begin
                on_nxt       = 2'b00;
                sounding_nxt = '0;
              end
            end
            REQ_CHECK: begin
              if (!(music_muted_r && effects_muted_r)) begin
                trk_nxt   = TRK_FX;
                act_nxt   = 1'b1;
                state_nxt = ST_CHK_START;
              end
            end
            default: ;
          endcase

          // start or clear a track for a play request that is not muted
          if ((in_data.req_type == REQ_PLAY_FX && !effects_muted_r) ||
              (in_data.req_type == REQ_PLAY_BG && !music_muted_r)) begin
            if (in_data.song_notes == '0) begin
              on_nxt[start_trk] = 1'b0;
            end else begin
              on_nxt[start_trk]    = 1'b1;
              base_nxt[start_trk]  = start_addr;
              addr_nxt[start_trk]  = start_addr;
              count_nxt[start_trk] = in_data.song_notes;
              loop_nxt[start_trk]  = in_data.song_repeats;
              pos_nxt[start_trk]   = '0;
              since_nxt[start_trk] = in_data.now_us;
              mem_addr             = start_addr;
              act_nxt              = start_snd;
              state_nxt            = ST_PLAY_RD;
            end
          end
        end
      end

      ST_PLAY_RD: begin
        if (act_r) begin
          sounding_nxt = mem_rdata.freq;
        end
        state_nxt = ST_DONE;
      end

      ST_CHK_START: begin
        if (!on_r[trk_r]) begin
          leave = 1'b1;
        end else begin
          state_nxt = ST_CHK_LEN;
        end
      end

      ST_CHK_LEN: begin
        state_nxt = ST_CHK_CMP;
      end

      ST_CHK_CMP: begin
        if (!chk_elapsed) begin
          leave = 1'b1;
          live  = 1'b1;
        end else begin
          since_nxt[trk_r] = now_r;
          if (goes_on) begin
            pos_nxt[trk_r]  = new_pos;
            addr_nxt[trk_r] = new_addr;
            if (act_r) begin
              mem_addr  = new_addr;
              state_nxt = ST_CHK_FRQ;
            end else begin
              leave = 1'b1;
              live  = 1'b1;
            end
          end else begin
            if (act_r) begin
              sounding_nxt = '0;
            end
            on_nxt[trk_r] = 1'b0;
            leave         = 1'b1;
          end
        end
      end

      ST_CHK_FRQ: begin
        sounding_nxt = mem_rdata.freq;
        leave        = 1'b1;
        live         = 1'b1;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{tone_freq:   sounding_r,
                            effect_busy: on_r[TRK_FX],
                            music_busy:  on_r[TRK_BG]};
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // move from effects to music, music sounds only if effects went quiet
    if (leave) begin
      if (trk_r == TRK_FX) begin
        trk_nxt   = TRK_BG;
        act_nxt   = !live;
        state_nxt = ST_CHK_START;
      end else begin
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      music_muted_r   <= 1'b0;
      effects_muted_r <= 1'b0;
      sounding_r      <= '0;
      on_r            <= 2'b00;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      music_muted_r   <= music_muted_nxt;
      effects_muted_r <= effects_muted_nxt;
      sounding_r      <= sounding_nxt;
      on_r            <= on_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    trk_r      <= trk_nxt;
    act_r      <= act_nxt;
    now_r      <= now_nxt;
    out_data_r <= out_data_nxt;
    loop_r     <= loop_nxt;
    base_r     <= base_nxt;
    addr_r     <= addr_nxt;
    count_r    <= count_nxt;
    pos_r      <= pos_nxt;
    since_r    <= since_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/two_track_note_sequencer_core.sv
// ----------------------------------------------------------------------------
// two_track_note_sequencer_core - two track note sequencer
// Plays songs from a note memory on an effects track and a music track.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry a request: write a note entry, play an effect, play
//   music, stop, or check the clock. Each request is taken when in_valid is
//   high and in_stall low, and gives exactly one output word with the tone
//   now driven to the buzzer and the busy flags of both tracks.
//   One request is in work at a time. A write, stop, unused code or muted
//   or empty play goes straight to the output register; a play first reads
//   the song's first frequency. A check visits each track: it passes over
//   an idle track, and on a playing one reads the length, registers it and
//   compares, then reads the new frequency when the sounding track moves
//   on. Only one track sounds, so a check makes at most one such read. The
//   word shows the cycle after the output register is loaded, when the next
//   request can be taken. All reads share the single note memory port, one
//   after another.
//   The output register lets a new request be taken while the last word
//   waits; a stalled receiver holds the sequencer in its final step after
//   that. The configuration port sets the two mute bits; write it only
//   while the block is idle.
//   Reset stops both tracks, silences the tone and clears the mutes; the
//   note memory keeps no reset value and needs writing before use.
// ----------------------------------------------------------------------------
module two_track_note_sequencer_core #(
  parameter int unsigned NOTE_DEPTH = ttns_pkg::NOTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ttns_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ttns_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_wdata
);
  import ttns_pkg::*;

  localparam int unsigned ADDR_W = $clog2(NOTE_DEPTH);

  // note memory port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  note_t             mem_wdata;
  note_t             mem_rdata;
  logic [NOTE_W-1:0] mem_rword;

  // length check
  logic [TIME_W-1:0] chk_now;
  logic [TIME_W-1:0] chk_since;
  logic              chk_elapsed;

  // Note memory: frequency and length side by side in one word
  ttns_ram #(
    .WIDTH (NOTE_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rword)
  );

  assign mem_rdata = note_t'(mem_rword);

  // Time since note start against note length, registered then compared
  ttns_elapsed u_elapsed (
    .clk      (clk),
    .now_us   (chk_now),
    .since_us (chk_since),
    .len_ms   (mem_rdata.len_ms),
    .elapsed  (chk_elapsed)
  );

  // Request sequencer with track state, tone and output register
  ttns_seq #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mem_we      (mem_we),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .chk_now     (chk_now),
    .chk_since   (chk_since),
    .chk_elapsed (chk_elapsed)
  );

endmodule
